/* hdl/rlsd_pkg.sv */
// ----------------------------------------------------------------------------
// rlsd_pkg
// Shared constants and types for the RGB LED matrix scan driver.
// ----------------------------------------------------------------------------
package rlsd_pkg;

  // Panel geometry
  localparam int PANEL_ROWS      = 16;
  localparam int PANEL_COLS      = 16;
  localparam int LINE_COLS       = 2 * PANEL_COLS;   // odd rows use upper half
  localparam int COL_W           = $clog2(LINE_COLS);
  localparam int PANEL_LINES     = PANEL_ROWS / 2;
  localparam int NUM_PLANES      = 3;                // green, blue, red

  // Defaults for the top-level parameters
  localparam int DEF_SCAN_LINES     = 8;
  localparam int DEF_BYTES_PER_LINE = 12;

  localparam int          ON_TIME_W     = 16;
  localparam logic [15:0] ON_TIME_RESET = 16'd2000;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Color planes inside one frame store word
  localparam int PLANE_GREEN = 0;
  localparam int PLANE_BLUE  = 1;
  localparam int PLANE_RED   = 2;

  // Pin states for one scan tick, before the data bit is known
  typedef struct packed {
    logic [2:0] row_select;
    logic       shift_clock;
    logic       latch_pulse;
    logic       enable_n;
    logic [1:0] plane;
    logic       plane_ok;
  } scan_pins_t;

endpackage

/* hdl/rlsd_ram.sv */
// ----------------------------------------------------------------------------
// rlsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/rlsd_frame_store.sv */
// ----------------------------------------------------------------------------
// rlsd_frame_store
// Pixel colors per scan line and column, cleared at reset via valid bits.
// ----------------------------------------------------------------------------
module rlsd_frame_store #(
  parameter int SCAN_LINES = rlsd_pkg::DEF_SCAN_LINES,
  parameter int LINE_W     = $clog2(SCAN_LINES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [3:0]                    pos_x,
  input  logic [3:0]                    pos_y,
  input  logic                          red_on,
  input  logic                          green_on,
  input  logic                          blue_on,
  input  logic                          rd_en,
  input  logic [LINE_W-1:0]             rd_line,
  input  logic [rlsd_pkg::COL_W-1:0]    rd_col,
  output logic [rlsd_pkg::NUM_PLANES-1:0] rd_bits
);

  import rlsd_pkg::*;

  // Pixel rows only reach PANEL_LINES scan lines
  localparam int STORE_LINES = (SCAN_LINES < PANEL_LINES) ? SCAN_LINES : PANEL_LINES;
  localparam int DEPTH       = STORE_LINES * LINE_COLS;
  localparam int AW          = $clog2(DEPTH);

  logic [2:0]            wr_line;
  logic [COL_W-1:0]      wr_col;
  logic                  wr_ok;
  logic [AW-1:0]         wr_addr;
  logic [NUM_PLANES-1:0] wr_data;
  logic                  rd_ok;
  logic [AW-1:0]         rd_addr;
  logic [NUM_PLANES-1:0] ram_rdata;
  logic [DEPTH-1:0]      valid_r;
  logic                  hit_r;

  assign wr_line = pos_y[3:1];
  assign wr_col  = {pos_y[0], pos_x};
  assign wr_ok   = wr_en && (int'(wr_line) < STORE_LINES);
  assign wr_addr = AW'({wr_line, wr_col});

  always_comb begin
    wr_data              = '0;
    wr_data[PLANE_GREEN] = green_on;
    wr_data[PLANE_BLUE]  = blue_on;
    wr_data[PLANE_RED]   = red_on;
  end

  assign rd_ok   = int'(rd_line) < STORE_LINES;
  assign rd_addr = AW'({rd_line, rd_col});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= rd_ok && valid_r[rd_addr];
      end
    end
  end

  rlsd_ram #(
    .WIDTH(NUM_PLANES),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_ok),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  assign rd_bits = hit_r ? ram_rdata : '0;

endmodule

/* hdl/rlsd_scan_seq.sv */
// ----------------------------------------------------------------------------
// rlsd_scan_seq
// Scan sequencer: shift, latch and lit phases per line, with pin states.
// ----------------------------------------------------------------------------
module rlsd_scan_seq #(
  parameter int SCAN_LINES     = rlsd_pkg::DEF_SCAN_LINES,
  parameter int BYTES_PER_LINE = rlsd_pkg::DEF_BYTES_PER_LINE,
  parameter int LINE_W         = $clog2(SCAN_LINES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick,
  input  logic [rlsd_pkg::ON_TIME_W-1:0] on_time,
  output logic                          rd_en,
  output logic [LINE_W-1:0]             rd_line,
  output logic [rlsd_pkg::COL_W-1:0]    rd_col,
  output rlsd_pkg::scan_pins_t          pins
);

  import rlsd_pkg::*;

  localparam int LINE_BITS = BYTES_PER_LINE * 8;
  localparam int BIT_W     = $clog2(LINE_BITS);

  typedef enum logic [1:0] {
    PH_SHIFT,
    PH_LATCH,
    PH_LIT
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [LINE_W-1:0]      line_r, line_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [ON_TIME_W-1:0]   lit_r, lit_nxt;
  logic [ON_TIME_W-1:0]   limit;
  logic [ON_TIME_W-1:0]   lit_inc;
  logic [BIT_W-1:0]       plane_full;

  assign limit      = (on_time == '0) ? ON_TIME_W'(1) : on_time;
  assign lit_inc    = lit_r + ON_TIME_W'(1);
  assign plane_full = bit_r >> COL_W;

  always_comb begin
    phase_nxt        = phase_r;
    line_nxt         = line_r;
    bit_nxt          = bit_r;
    lit_nxt          = lit_r;
    pins             = '0;
    pins.row_select  = ~3'(line_r);
    pins.enable_n    = 1'b1;
    pins.plane       = 2'(plane_full);
    pins.plane_ok    = plane_full < BIT_W'(NUM_PLANES);
    rd_en            = 1'b0;
    unique case (phase_r)
      PH_SHIFT: begin
        pins.shift_clock = 1'b1;
        rd_en            = tick;
        if (tick) begin
          if (bit_r == BIT_W'(LINE_BITS - 1)) begin
            bit_nxt   = '0;
            phase_nxt = PH_LATCH;
          end else begin
            bit_nxt = bit_r + BIT_W'(1);
          end
        end
      end
      PH_LATCH: begin
        pins.latch_pulse = 1'b1;
        if (tick) begin
          lit_nxt   = '0;
          phase_nxt = PH_LIT;
        end
      end
      PH_LIT: begin
        pins.enable_n = 1'b0;
        if (tick) begin
          lit_nxt = lit_inc;
          if (lit_inc >= limit) begin
            lit_nxt   = '0;
            bit_nxt   = '0;
            phase_nxt = PH_SHIFT;
            line_nxt  = (line_r == LINE_W'(SCAN_LINES - 1)) ? '0 : line_r + LINE_W'(1);
          end
        end
      end
      default: begin
        phase_nxt = PH_SHIFT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SHIFT;
      line_r  <= '0;
      bit_r   <= '0;
      lit_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      bit_r   <= bit_nxt;
      lit_r   <= lit_nxt;
    end
  end

  assign rd_line = line_r;
  assign rd_col  = bit_r[COL_W-1:0];

endmodule

/* hdl/rgb_led_matrix_scan_driver.sv */
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver
// Frame store and scan sequencer for a 16x16 multiplexed RGB LED panel.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid / in_stall) are either a pixel write, which
//   stores three color bits and gives no result, or a scan tick, which
//   gives one result with the panel pin states for that tick.
//   Results leave on out_valid / out_stall. One request is taken per
//   cycle while in_stall is low; a tick result is registered first at
//   the taking edge (sequencer and frame store read), then in the output
//   register. The frame store's registered read port sets the first stage.
//   When the receiver stalls, the output register and one tick in
//   flight hold, and in_stall rises until the output register drains.
//   cfg_valid / cfg_ready write the on_time register (lit ticks per
//   line); cfg_ready is always high.
//   After reset the frame store reads as all dark, the scan starts with
//   the shift phase of line 0 and on_time is 2000.
// ----------------------------------------------------------------------------
module rgb_led_matrix_scan_driver #(
  parameter int SCAN_LINES     = rlsd_pkg::DEF_SCAN_LINES,
  parameter int BYTES_PER_LINE = rlsd_pkg::DEF_BYTES_PER_LINE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [3:0]                     in_pos_x,
  input  logic [3:0]                     in_pos_y,
  input  logic                           in_red_on,
  input  logic                           in_green_on,
  input  logic                           in_blue_on,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_row_select,
  output logic                           out_serial_data,
  output logic                           out_shift_clock,
  output logic                           out_latch_pulse,
  output logic                           out_enable_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlsd_pkg::ON_TIME_W-1:0] cfg_data
);

  import rlsd_pkg::*;

  localparam int LINE_W = $clog2(SCAN_LINES);

  logic                  accept;
  logic                  tick_acc;
  logic                  write_acc;
  logic                  out_load;
  logic [ON_TIME_W-1:0]  on_time_r;
  logic                  rd_en;
  logic [LINE_W-1:0]     rd_line;
  logic [COL_W-1:0]      rd_col;
  logic [NUM_PLANES-1:0] rd_bits;
  scan_pins_t            pins;
  scan_pins_t            s1_pins_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  data_bit;
  logic [2:0]            row_select_r;
  logic                  serial_data_r;
  logic                  shift_clock_r;
  logic                  latch_pulse_r;
  logic                  enable_n_r;

  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign accept    = in_valid && !in_stall;
  assign tick_acc  = accept && (in_operation == OP_TICK);
  assign write_acc = accept && (in_operation == OP_WRITE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r <= ON_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      on_time_r <= cfg_data;
    end
  end

  rlsd_scan_seq #(
    .SCAN_LINES    (SCAN_LINES),
    .BYTES_PER_LINE(BYTES_PER_LINE),
    .LINE_W        (LINE_W)
  ) u_scan_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick_acc),
    .on_time(on_time_r),
    .rd_en  (rd_en),
    .rd_line(rd_line),
    .rd_col (rd_col),
    .pins   (pins)
  );

  rlsd_frame_store #(
    .SCAN_LINES(SCAN_LINES),
    .LINE_W    (LINE_W)
  ) u_frame_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (write_acc),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .red_on  (in_red_on),
    .green_on(in_green_on),
    .blue_on (in_blue_on),
    .rd_en   (rd_en),
    .rd_line (rd_line),
    .rd_col  (rd_col),
    .rd_bits (rd_bits)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (tick_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
    data_bit      = s1_pins_r.shift_clock && s1_pins_r.plane_ok &&
                    rd_bits[s1_pins_r.plane];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_pins_r <= pins;
    end
    if (out_load && s1_valid_r) begin
      row_select_r  <= s1_pins_r.row_select;
      serial_data_r <= data_bit;
      shift_clock_r <= s1_pins_r.shift_clock;
      latch_pulse_r <= s1_pins_r.latch_pulse;
      enable_n_r    <= s1_pins_r.enable_n;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_select  = row_select_r;
  assign out_serial_data = serial_data_r;
  assign out_shift_clock = shift_clock_r;
  assign out_latch_pulse = latch_pulse_r;
  assign out_enable_n    = enable_n_r;

endmodule
